// ===== rtl/assert_macros.svh =====
// assertion macros shared by the console rtl
// every macro samples on clock and is disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define TCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define TCC_ASSERT_IMPL(label, ante, cons, msg) \
   `TCC_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
   `TCC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/tcc_pkg.sv =====
// shared types and constants for the text console core
// no dependencies
`default_nettype none

package tcc_pkg;

   localparam int ADDR_WIDTH = 11;
   localparam int CHAR_WIDTH = 8;

   localparam logic [CHAR_WIDTH-1:0] NEWLINE_CODE = 8'h0a;
   localparam logic [CHAR_WIDTH-1:0] SPACE_CODE   = 8'h20;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_scroll_core.sv =====
// teletype console: put runs ST_PUT then ST_DONE to the result beat, newline or wrap
// that scrolls adds a one-row blanking sweep (ST_BLANK), read runs ST_RD_ADDR,
// ST_RD_DATA if in range, ST_DONE, clear sweeps all cells; the next command is taken
// in the cycle the result strobe is shown, so only one command is in flight at a time
// reset: afterwards every store cell is swept to spaces, busy high
// meanwhile; the result strobe is a one-cycle beat, the receiver cannot stall
`default_nettype none
`include "assert_macros.svh"

module text_console_cursor_scroll_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [1:0]                       req_operation,
   input  wire  [tcc_pkg::CHAR_WIDTH-1:0]   req_char_code,
   input  wire  [tcc_pkg::ADDR_WIDTH-1:0]   req_cell_address,
   output logic                             rsp_valid,
   output logic [tcc_pkg::ADDR_WIDTH-1:0]   rsp_cursor_position,
   output logic [tcc_pkg::CHAR_WIDTH-1:0]   rsp_cell_value
);
   import tcc_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS);
   // wide enough for both the request address and a store address, plus headroom
   localparam int LW = ((AW > ADDR_WIDTH) ? AW : ADDR_WIDTH) + 1;
   localparam logic [AW:0] CELLS_WIDE = (AW+1)'(CELL_COUNT);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_PUT,
      ST_BLANK,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [AW-1:0]    row_base_ff, row_base_in;   // row_ff * COLUMNS
   logic [AW-1:0]    top_base_ff, top_base_in;   // store offset of the top screen row
   logic [AW-1:0]    sweep_base_ff, sweep_base_in;
   logic [AW-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [CHAR_WIDTH-1:0] char_ff, char_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [CHAR_WIDTH-1:0] cell_ff, cell_in;
   logic [ADDR_WIDTH-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CHAR_WIDTH-1:0] rsp_cell_ff, rsp_cell_in;

   // store ports
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [CHAR_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [CHAR_WIDTH-1:0] mem_rdata;

   // address arithmetic
   logic [AW-1:0]  cursor_lin;
   logic [LW-1:0]  read_ext;
   logic           read_in_range;
   logic [AW-1:0]  lin_sel;
   logic [AW:0]    phys_sum;
   logic [AW-1:0]  phys_addr;
   logic [AW-1:0]  sweep_addr;
   logic [AW:0]    top_next_sum;
   logic [AW-1:0]  top_wrapped;
   logic [LW-1:0]  pos_ext;
   logic           is_newline;
   logic           last_col;
   logic           last_row;
   logic           sweep_end_all;
   logic           sweep_end_row;

   tcc_ram #(
      .DEPTH (CELL_COUNT),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // logical screen position of the cursor, row major
   assign cursor_lin = row_base_ff + AW'(col_ff);

   // read address range check done wide so any parameter set works
   assign read_ext      = LW'(addr_ff);
   assign read_in_range = read_ext < LW'(CELL_COUNT);

   // scrolling rotates the store: logical cell maps to (top + lin) mod cells
   assign lin_sel   = (state_ff == ST_RD_ADDR) ? read_ext[AW-1:0] : cursor_lin;
   assign phys_sum  = {1'b0, top_base_ff} + {1'b0, lin_sel};
   assign phys_addr = (phys_sum >= CELLS_WIDE) ? AW'(phys_sum - CELLS_WIDE)
                                               : phys_sum[AW-1:0];

   // sweeps run over contiguous cells, a whole store or one physical row
   assign sweep_addr = sweep_base_ff + sweep_cnt_ff;

   // top row offset after a scroll; it is a row multiple so it hits the end exactly
   assign top_next_sum = {1'b0, top_base_ff} + (AW+1)'(COLUMNS);
   assign top_wrapped  = (top_next_sum >= CELLS_WIDE) ? '0 : top_next_sum[AW-1:0];

   assign pos_ext = LW'(cursor_lin);

   assign is_newline    = char_ff == NEWLINE_CODE;
   assign last_col      = col_ff == CW'(COLUMNS - 1);
   assign last_row      = row_ff == RW'(ROWS - 1);
   assign sweep_end_all = sweep_cnt_ff == AW'(CELL_COUNT - 1);
   assign sweep_end_row = sweep_cnt_ff == AW'(COLUMNS - 1);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      row_base_in   = row_base_ff;
      top_base_in   = top_base_ff;
      sweep_base_in = sweep_base_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      rsp_valid_in  = 1'b0;
      char_in       = char_ff;
      addr_in       = addr_ff;
      cell_in       = cell_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_cell_in   = rsp_cell_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_addr;
      mem_wdata     = SPACE_CODE;
      mem_re        = 1'b0;
      mem_raddr     = phys_addr;

      unique case (state_ff)
         // reset clearing pass, one cell a cycle
         ST_INIT: begin
            mem_we = 1'b1;
            if (sweep_end_all) begin
               state_in = ST_IDLE;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (start) begin
               char_in = req_char_code;
               addr_in = req_cell_address;
               cell_in = '0;
               unique case (op_type'(req_operation))
                  OP_PUT: begin
                     state_in = ST_PUT;
                  end
                  OP_CLEAR: begin
                     sweep_base_in = '0;
                     sweep_cnt_in  = '0;
                     state_in      = ST_CLEAR;
                  end
                  OP_READ: begin
                     state_in = ST_RD_ADDR;
                  end
                  OP_NONE: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // clear keeps the cursor and the rotation, only the cells change
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (sweep_end_all) begin
               state_in = ST_DONE;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + 1'b1;
            end
         end

         // store the character unless it is a newline, then advance with an immediate wrap
         ST_PUT: begin
            if (!is_newline) begin
               mem_we    = 1'b1;
               mem_waddr = phys_addr;
               mem_wdata = char_ff;
            end
            if (is_newline || last_col) begin
               col_in = '0;
               if (last_row) begin
                  // old top row becomes the new bottom row, blank it
                  sweep_base_in = top_base_ff;
                  sweep_cnt_in  = '0;
                  top_base_in   = top_wrapped;
                  state_in      = ST_BLANK;
               end else begin
                  row_in      = row_ff + 1'b1;
                  row_base_in = row_base_ff + AW'(COLUMNS);
                  state_in    = ST_DONE;
               end
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_BLANK: begin
            mem_we = 1'b1;
            if (sweep_end_row) begin
               state_in = ST_DONE;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + 1'b1;
            end
         end

         // all writes of earlier commands have landed, so no forwarding here
         ST_RD_ADDR: begin
            if (read_in_range) begin
               mem_re   = 1'b1;
               state_in = ST_RD_DATA;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_RD_DATA: begin
            cell_in  = mem_rdata;
            state_in = ST_DONE;
         end

         // result beat shows in the following idle cycle
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = pos_ext[ADDR_WIDTH-1:0];
            rsp_cell_in  = cell_ff;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         row_ff        <= '0;
         col_ff        <= '0;
         row_base_ff   <= '0;
         top_base_ff   <= '0;
         sweep_base_ff <= '0;
         sweep_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         row_base_ff   <= row_base_in;
         top_base_ff   <= top_base_in;
         sweep_base_ff <= sweep_base_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      char_ff     <= char_in;
      addr_ff     <= addr_in;
      cell_ff     <= cell_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign busy                = state_ff != ST_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_value      = rsp_cell_ff;

   // result beats only while idle and never two in a row
   `TCC_ASSERT_IMPL(a_rsp_when_idle, rsp_valid, !busy, "result beat while busy")
   `TCC_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result beat repeated")
   // an accepted command always occupies the block next cycle
   `TCC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept without busy")
   // writes stay inside the store
   `TCC_ASSERT_IMPL(a_waddr_range, mem_we, ({1'b0, mem_waddr} < CELLS_WIDE),
      "store write out of range")
   // cursor row and its base stay consistent and on screen
   `TCC_ASSERT(a_row_range, (row_ff <= RW'(ROWS - 1) && {1'b0, row_base_ff} < CELLS_WIDE),
      "cursor row off screen")

endmodule

`default_nettype wire

// ===== rtl/tcc_ram.sv =====
// character store: one write port, one read port, registered read data
// depends on tcc_pkg for the character width
`default_nettype none

module tcc_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  wire                              clock,
   input  wire                              wr_en,
   input  wire  [AW-1:0]                    wr_addr,
   input  wire  [tcc_pkg::CHAR_WIDTH-1:0]   wr_data,
   input  wire                              rd_en,
   input  wire  [AW-1:0]                    rd_addr,
   output logic [tcc_pkg::CHAR_WIDTH-1:0]   rd_data
);
   import tcc_pkg::*;

   logic [CHAR_WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
